>>> rtl/pir_pkg.sv
`default_nettype none

package pir_pkg;

  // configuration register indexes
  localparam logic CFG_IMAGE_ROWS = 1'b0;
  localparam logic CFG_IMAGE_COLS = 1'b1;

  // item kinds carried on s_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int unsigned SIZE_W  = 9;   // width of image_rows / image_cols
  localparam int unsigned COORD_W = 8;   // width of row/angle and col/radius fields
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned TRIG_W  = 17;  // Q2.15 magnitude with 1.0 held as 32768
  localparam int unsigned PROD_W  = COORD_W + TRIG_W;
  localparam int unsigned XN_W    = PROD_W + 1;
  localparam int unsigned FRAC_W  = 15;

  localparam logic [PIX_W-1:0] BLACK_WORD = 32'h0000_00FF;

  localparam logic [SIZE_W-1:0] RESET_ROWS = 9'd256;
  localparam logic [SIZE_W-1:0] RESET_COLS = 9'd128;

  // round(sin(d) * 32768) for d = 0..90 degrees
  localparam logic [TRIG_W-1:0] SINE_Q15 [0:90] = '{
    17'd0,     17'd572,   17'd1144,  17'd1715,  17'd2286,  17'd2856,  17'd3425,
    17'd3993,  17'd4560,  17'd5126,  17'd5690,  17'd6252,  17'd6813,  17'd7371,
    17'd7927,  17'd8481,  17'd9032,  17'd9580,  17'd10126, 17'd10668, 17'd11207,
    17'd11743, 17'd12275, 17'd12803, 17'd13328, 17'd13848, 17'd14365, 17'd14876,
    17'd15384, 17'd15886, 17'd16384, 17'd16877, 17'd17364, 17'd17847, 17'd18324,
    17'd18795, 17'd19261, 17'd19720, 17'd20174, 17'd20622, 17'd21063, 17'd21498,
    17'd21926, 17'd22348, 17'd22763, 17'd23170, 17'd23571, 17'd23965, 17'd24351,
    17'd24730, 17'd25102, 17'd25466, 17'd25822, 17'd26170, 17'd26510, 17'd26842,
    17'd27166, 17'd27482, 17'd27789, 17'd28088, 17'd28378, 17'd28660, 17'd28932,
    17'd29197, 17'd29452, 17'd29698, 17'd29935, 17'd30163, 17'd30382, 17'd30592,
    17'd30792, 17'd30983, 17'd31164, 17'd31336, 17'd31499, 17'd31651, 17'd31795,
    17'd31928, 17'd32052, 17'd32166, 17'd32270, 17'd32365, 17'd32449, 17'd32524,
    17'd32588, 17'd32643, 17'd32688, 17'd32723, 17'd32748, 17'd32763, 17'd32768
  };

endpackage

`default_nettype wire

>>> rtl/pir_frame_store.sv
`default_nettype none

module pir_frame_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic                    re,
  input  wire logic [AW-1:0]           addr,
  input  wire logic [pir_pkg::PIX_W-1:0] wdata,
  output logic      [pir_pkg::PIX_W-1:0] rdata
);
  import pir_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/polar_image_remap.sv
`default_nettype none

// Polar image remap.
// Slave stream: s_tuser = opcode (0 write pixel, 1 polar lookup);
//   s_tdata[7:0] row/angle, [15:8] col/radius, [47:16] pixel.
// A write stores the pixel at (row, col) if it lies inside the image and
// gives no word out. A lookup gives one word on the master stream:
//   m_tdata = stored pixel at x = rows/2 - r*cos(a), y = r*sin(a), or black
//   0x000000FF with m_tuser = 1 when the position lies outside the image.
// Config: cfg_we/cfg_addr/cfg_data write image_rows (0) or image_cols (1);
//   write them only while nothing is in flight.
// Timing: five pipeline stages (trig table, multiply, x sum, range check and
// frame store access, registered read data). One item per clock is taken
// while s_tready is high; the single port of the frame store serves one
// write or one read per cycle, in item order.
// When the receiver stalls the held result stays on m_tdata, earlier stages
// keep filling until a stage meets a held lookup, then s_tready drops.
// Reset empties the pipeline and sets rows 256, cols 128; the frame store
// is not cleared and a pixel must be written before it is looked up.
module polar_image_remap #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // row_or_angle, col_or_radius, pixel_in
  input  wire logic        s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // pixel_out
  output logic             m_tuser,   // outside
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [8:0]  cfg_data
);
  import pir_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);

  // configuration
  logic [SIZE_W-1:0] image_rows;
  logic [SIZE_W-1:0] image_cols;
  logic [SIZE_W-1:0] eff_rows;
  logic [SIZE_W-1:0] eff_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= RESET_ROWS;
      image_cols <= RESET_COLS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_ROWS: image_rows <= cfg_data;
        CFG_IMAGE_COLS: image_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_rows == '0) eff_rows = SIZE_W'(1);
    else if (32'(image_rows) > 32'(MAX_ROWS)) eff_rows = SIZE_W'(MAX_ROWS);
    else eff_rows = image_rows;
    if (image_cols == '0) eff_cols = SIZE_W'(1);
    else if (32'(image_cols) > 32'(MAX_COLS)) eff_cols = SIZE_W'(MAX_COLS);
    else eff_cols = image_cols;
  end

  // input fields
  logic               in_op;
  logic [COORD_W-1:0] in_a;
  logic [COORD_W-1:0] in_b;
  logic [PIX_W-1:0]   in_pix;

  assign in_op  = s_tuser;
  assign in_a   = s_tdata[7:0];
  assign in_b   = s_tdata[15:8];
  assign in_pix = s_tdata[47:16];

  // quadrant reduction of a whole-degree angle below 360
  logic [8:0]        sin_deg;
  logic [8:0]        cos_deg;
  logic [6:0]        sin_idx;
  logic [6:0]        cos_idx;
  logic              sin_neg_in;
  logic              cos_neg_in;

  assign sin_deg = {1'b0, in_a};
  assign cos_deg = {1'b0, in_a} + 9'd90;

  always_comb begin
    if (sin_deg <= 9'd90) begin
      sin_idx = 7'(sin_deg);            sin_neg_in = 1'b0;
    end else if (sin_deg <= 9'd180) begin
      sin_idx = 7'(9'd180 - sin_deg);   sin_neg_in = 1'b0;
    end else if (sin_deg <= 9'd270) begin
      sin_idx = 7'(sin_deg - 9'd180);   sin_neg_in = 1'b1;
    end else begin
      sin_idx = 7'(9'd360 - sin_deg);   sin_neg_in = 1'b1;
    end
    if (cos_deg <= 9'd90) begin
      cos_idx = 7'(cos_deg);            cos_neg_in = 1'b0;
    end else if (cos_deg <= 9'd180) begin
      cos_idx = 7'(9'd180 - cos_deg);   cos_neg_in = 1'b0;
    end else if (cos_deg <= 9'd270) begin
      cos_idx = 7'(cos_deg - 9'd180);   cos_neg_in = 1'b1;
    end else begin
      cos_idx = 7'(9'd360 - cos_deg);   cos_neg_in = 1'b1;
    end
  end

  // pipeline registers
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic a_op, b_op, c_op, d_op;
  logic [COORD_W-1:0] a_row, b_row, c_row, d_row;
  logic [COORD_W-1:0] a_col, b_col, c_col, d_col;
  logic [PIX_W-1:0]   a_pix, b_pix, c_pix, d_pix;
  logic [TRIG_W-1:0]  a_sin, a_cos;
  logic               a_sin_neg, a_cos_neg, b_cos_neg;
  logic               b_sin_neg;
  logic [PROD_W-1:0]  b_psin, b_pcos;
  logic signed [XN_W-1:0] c_xn, d_xn;
  logic [PROD_W-FRAC_W-1:0] c_ymag, d_ymag;
  logic               c_yneg, d_yneg;
  logic               e_outside;
  logic [PIX_W-1:0]   ram_q;

  // handshake through the stages: a stage frees when its item moves on
  logic e_hold, d_lookup, d_move, d_free, c_free, b_free, a_free;

  assign e_hold   = e_valid && !m_tready;
  assign d_lookup = (d_op == OP_LOOKUP);
  assign d_move   = d_valid && (!d_lookup || !e_hold);
  assign d_free   = !d_valid || d_move;
  assign c_free   = !c_valid || d_free;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign s_tready = a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (a_free) a_valid <= s_tvalid;
      if (b_free) b_valid <= a_valid;
      if (c_free) c_valid <= b_valid;
      if (d_free) d_valid <= c_valid;
    end
  end

  // stage A: trig tables
  always_ff @(posedge clk) begin
    if (a_free) begin
      a_op      <= in_op;
      a_row     <= in_a;
      a_col     <= in_b;
      a_pix     <= in_pix;
      a_sin     <= SINE_Q15[sin_idx];
      a_cos     <= SINE_Q15[cos_idx];
      a_sin_neg <= sin_neg_in;
      a_cos_neg <= cos_neg_in;
    end
  end

  // stage B: radius times sine and cosine magnitudes
  always_ff @(posedge clk) begin
    if (b_free) begin
      b_op      <= a_op;
      b_row     <= a_row;
      b_col     <= a_col;
      b_pix     <= a_pix;
      b_psin    <= PROD_W'(a_col) * PROD_W'(a_sin);
      b_pcos    <= PROD_W'(a_col) * PROD_W'(a_cos);
      b_sin_neg <= a_sin_neg;
      b_cos_neg <= a_cos_neg;
    end
  end

  // stage C: x in Q.15, y magnitude truncated toward zero
  logic signed [XN_W-1:0] half_q;
  logic signed [XN_W-1:0] pcos_s;

  assign half_q = XN_W'({eff_rows[SIZE_W-1:1], {FRAC_W{1'b0}}});
  assign pcos_s = XN_W'(b_pcos);

  always_ff @(posedge clk) begin
    if (c_free) begin
      c_op   <= b_op;
      c_row  <= b_row;
      c_col  <= b_col;
      c_pix  <= b_pix;
      c_xn   <= b_cos_neg ? (half_q + pcos_s) : (half_q - pcos_s);
      c_ymag <= b_psin[PROD_W-1:FRAC_W];
      c_yneg <= b_sin_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (d_free) begin
      d_op   <= c_op;
      d_row  <= c_row;
      d_col  <= c_col;
      d_pix  <= c_pix;
      d_xn   <= c_xn;
      d_ymag <= c_ymag;
      d_yneg <= c_yneg;
    end
  end

  // stage D: range checks and frame store access
  logic                   x_neg;
  logic [XN_W-FRAC_W-2:0] x_pos;
  logic                   x_ok, y_ok, d_outside, wr_ok;
  logic [RW-1:0]          row_idx;
  logic [CW-1:0]          col_idx;
  logic [AW-1:0]          mem_addr;

  assign x_neg = d_xn[XN_W-1];
  assign x_pos = d_xn[XN_W-2:FRAC_W];

  always_comb begin
    // a negative x above -1 truncates to row zero
    if (x_neg) x_ok = (&d_xn[XN_W-1:FRAC_W]) && (|d_xn[FRAC_W-1:0]);
    else x_ok = (32'(x_pos) < 32'(eff_rows));
    // a negative y of magnitude below one truncates to column zero
    y_ok = !(d_yneg && (d_ymag != '0)) && (32'(d_ymag) < 32'(eff_cols));
    d_outside = !(x_ok && y_ok);
    wr_ok = (32'(d_row) < 32'(eff_rows)) && (32'(d_col) < 32'(eff_cols));
    if (d_lookup) begin
      row_idx = x_neg ? '0 : RW'(x_pos);
      col_idx = CW'(d_ymag);
    end else begin
      row_idx = RW'(d_row);
      col_idx = CW'(d_col);
    end
    mem_addr = AW'(32'(row_idx) * 32'(MAX_COLS)) + AW'(col_idx);
  end

  pir_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (d_move && !d_lookup && wr_ok),
    .re    (d_move && d_lookup),
    .addr  (mem_addr),
    .wdata (d_pix),
    .rdata (ram_q)
  );

  // stage E: output word
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (d_move && d_lookup) begin
      e_valid <= 1'b1;
    end else if (m_tready) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (d_move && d_lookup) begin
      e_outside <= d_outside;
    end
  end

  assign m_tvalid = e_valid;
  assign m_tdata  = e_outside ? BLACK_WORD : ram_q;
  assign m_tuser  = e_outside;

`ifndef SYNTHESIS
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!a_valid && !b_valid && !c_valid && !d_valid && !e_valid) |-> s_tready)
    else $error("pipeline empty but input not ready");

  a_held_lookup: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d_lookup && e_hold) |=> (d_valid && e_valid))
    else $error("lookup left stage D while output word was held");

  a_outside_black: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == BLACK_WORD))
    else $error("outside word is not black");

  a_write_no_word: assert property (@(posedge clk) disable iff (rst)
    (d_move && !d_lookup && !e_valid) |=> !e_valid)
    else $error("write item produced an output word");
`endif

endmodule

`default_nettype wire
